/* hw/rtl/slip_frame_decoder_crc_assert.svh */
// Assertion macros for the SLIP decoder RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef SLIP_FRAME_DECODER_CRC_ASSERT_SVH
`define SLIP_FRAME_DECODER_CRC_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFD_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFD_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sfd_pkg.sv */
// Shared types and constants of the SLIP frame decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

	// SLIP codes
	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	localparam int MIN_FRAME_BYTES = 4;
	localparam int CRC_BYTES       = 2;

	// result status codes
	localparam logic [2:0] ST_CONT    = 3'd0;
	localparam logic [2:0] ST_OK      = 3'd1;
	localparam logic [2:0] ST_LEN_ERR = 3'd2;
	localparam logic [2:0] ST_ESC_ERR = 3'd3;
	localparam logic [2:0] ST_CRC_ERR = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_LEN   = 2'd0;
	localparam logic [1:0] CFG_CRC_POLY  = 2'd1;
	localparam logic [1:0] CFG_CRC_INIT  = 2'd2;
	localparam logic [1:0] CFG_CRC_FXOR  = 2'd3;

	// configuration reset values
	localparam logic [8:0]  MAX_LEN_RST  = 9'd256;
	localparam logic [15:0] CRC_POLY_RST = 16'h1021;
	localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;
	localparam logic [15:0] CRC_FXOR_RST = 16'h0000;

	typedef struct packed {
		logic [8:0]  max_len;
		logic [15:0] poly;
		logic [15:0] init;
		logic [15:0] fxor;
	} cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] flen;
	} res_t;

endpackage

`default_nettype wire

/* hw/rtl/slip_frame_decoder_crc.sv */
// Top level of the SLIP frame decoder with CRC16 check.
// Depends on sfd_pkg, sfd_ram, sfd_parser and the assertion macro header.
//
//  channel  | dir | handshake              | contents
//  ---------+-----+------------------------+---------------------------------
//  s_axis   | in  | tvalid / tready        | tuser action, tdata rx_byte, index
//  m_axis   | out | tvalid / tready        | tuser status, tdata length, data
//  cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (16 bits)
//
// One beat per cycle in and out while the output is not held; a result passes
// through the payload store read port (stage s1) and then the output register.
// Parse state updates in the accept cycle, so a beat may follow every cycle.
// Pipeline stage s1 plus the output register: input stalls only when both
// are full and m_axis_tready is low.
// Reset clears control state and loads the register defaults; the store is
// not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "slip_frame_decoder_crc_assert.svh"

module slip_frame_decoder_crc #(
	parameter int STORE_DEPTH = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	// slave side
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] read_index
	input  wire         s_axis_tuser,   // [0] action
	// master side
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] frame_length, [15:8] read_data
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	// configuration writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	localparam int AW = $clog2(STORE_DEPTH);

	sfd_pkg::cfg_t cfg_q;
	sfd_pkg::res_t res;

	logic          s_accept;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic          idx_ok;

	// stage 1: status of the beat, store data arrives this cycle
	logic          valid_s1;
	sfd_pkg::res_t res_s1;
	logic          rd_ok_s1;
	logic          s1_move;

	// output register
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [7:0]    out_flen_q;
	logic [7:0]    out_rdata_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len <= sfd_pkg::MAX_LEN_RST;
			cfg_q.poly    <= sfd_pkg::CRC_POLY_RST;
			cfg_q.init    <= sfd_pkg::CRC_INIT_RST;
			cfg_q.fxor    <= sfd_pkg::CRC_FXOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfd_pkg::CFG_MAX_LEN:  cfg_q.max_len <= cfg_data[8:0];
				sfd_pkg::CFG_CRC_POLY: cfg_q.poly    <= cfg_data;
				sfd_pkg::CFG_CRC_INIT: cfg_q.init    <= cfg_data;
				sfd_pkg::CFG_CRC_FXOR: cfg_q.fxor    <= cfg_data;
			endcase
		end
	end

	// s1 advances when the output slot is free or being drained
	assign s1_move       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_move;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// read index beyond the store returns zero
	assign idx_ok    = (32'(s_axis_tdata[15:8]) < 32'(STORE_DEPTH));
	assign ram_re    = s_accept && s_axis_tuser;
	assign ram_raddr = AW'(s_axis_tdata[15:8]);

	sfd_parser #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (s_accept),
		.action  (s_axis_tuser),
		.rx_byte (s_axis_tdata[7:0]),
		.cfg     (cfg_q),
		.res     (res),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata)
	);

	sfd_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			res_s1   <= res;
			rd_ok_s1 <= s_axis_tuser && idx_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	// store output holds while s1 waits: no new read is issued then
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_status_q <= res_s1.status;
			out_flen_q   <= res_s1.flen;
			out_rdata_q  <= rd_ok_s1 ? ram_rdata : 8'h00;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_rdata_q, out_flen_q};

	`SFD_ASSERT_NOW(a_stall_full, valid_s1 && out_valid_q && !m_axis_tready, !s_axis_tready, "input taken while pipeline full")
	`SFD_ASSERT_NEXT(a_read_lands, ram_re, valid_s1, "store read without a stage 1 beat")
	`SFD_ASSERT_NOW(a_rdata_zero, out_valid_q && (out_status_q != sfd_pkg::ST_CONT), out_rdata_q == 8'h00, "read data on a frame status beat")
	`SFD_ASSERT_NOW(a_ok_len, out_valid_q && (out_status_q == sfd_pkg::ST_OK), out_flen_q >= 8'd3, "frame ok with short length")

endmodule

`default_nettype wire

/* hw/rtl/sfd_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sfd_parser.sv */
// SLIP unescape, frame state and CRC16 tracking; drives the payload store writes.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser #(
	parameter int STORE_DEPTH = 256
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            accept,
	input  wire                            action,
	input  wire [7:0]                      rx_byte,
	input  wire sfd_pkg::cfg_t             cfg,
	output sfd_pkg::res_t                  res,
	output logic                           we,
	output logic [$clog2(STORE_DEPTH)-1:0] waddr,
	output logic [7:0]                     wdata
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int CW   = $clog2(STORE_DEPTH + 1);
	localparam int CAPW = (CW > 9) ? CW : 9;

	logic [CW-1:0] wcount_q;
	logic          in_frame_q;
	logic          esc_q;
	logic [15:0]   crc_q;
	logic [7:0]    held0_q;
	logic [7:0]    held1_q;

	logic [CW-1:0] wcount_d;
	logic          in_frame_d;
	logic          esc_d;
	logic [15:0]   crc_d;
	logic [7:0]    held0_d;
	logic [7:0]    held1_d;

	logic          do_store;
	logic [7:0]    sval;
	logic          restart;
	logic          set_frame;
	logic          full;
	logic [CAPW-1:0] cap;
	logic [CW-1:0] n_payload;
	logic [15:0]   crc_base;

	// one byte through the MSB-first shift register
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
		input logic [7:0] b, input logic [15:0] poly);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	assign cap = (CAPW'(cfg.max_len) < CAPW'(STORE_DEPTH)) ? CAPW'(cfg.max_len)
		: CAPW'(STORE_DEPTH);
	assign full      = (CAPW'(wcount_q) >= cap);
	assign n_payload = wcount_q - CW'(sfd_pkg::CRC_BYTES);
	// first CRC byte starts from the init value
	assign crc_base  = (wcount_q == CW'(sfd_pkg::CRC_BYTES)) ? cfg.init : crc_q;

	always_comb begin
		do_store   = 1'b0;
		sval       = '0;
		restart    = 1'b0;
		set_frame  = 1'b0;
		esc_d      = esc_q;
		res.status = sfd_pkg::ST_CONT;
		res.flen   = '0;
		we         = 1'b0;
		waddr      = wcount_q[AW-1:0];
		wdata      = '0;
		wcount_d   = wcount_q;
		crc_d      = crc_q;
		held0_d    = held0_q;
		held1_d    = held1_q;
		in_frame_d = in_frame_q;

		priority if (action) begin
			// read: no state change
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (rx_byte == sfd_pkg::SLIP_ESC_ESC) begin
				do_store = 1'b1;
				sval     = sfd_pkg::SLIP_ESC;
			end else if (rx_byte == sfd_pkg::SLIP_ESC_END) begin
				do_store = 1'b1;
				sval     = sfd_pkg::SLIP_END;
			end else begin
				restart    = 1'b1;
				res.status = sfd_pkg::ST_ESC_ERR;
			end
		end else if (rx_byte == sfd_pkg::SLIP_END) begin
			restart = 1'b1;
			if (in_frame_q && (wcount_q > CW'(sfd_pkg::MIN_FRAME_BYTES))) begin
				if ((crc_q ^ cfg.fxor) == {held0_q, held1_q}) begin
					res.status = sfd_pkg::ST_OK;
					res.flen   = (32'(n_payload) > 32'd255) ? 8'd255 : 8'(n_payload);
				end else begin
					res.status = sfd_pkg::ST_CRC_ERR;
				end
			end else begin
				set_frame = 1'b1;
			end
		end else if (rx_byte == sfd_pkg::SLIP_ESC) begin
			esc_d = 1'b1;
		end else begin
			do_store = 1'b1;
			sval     = rx_byte;
		end

		if (do_store) begin
			if (full) begin
				restart    = 1'b1;
				res.status = sfd_pkg::ST_LEN_ERR;
			end else begin
				we       = 1'b1;
				wdata    = sval;
				wcount_d = wcount_q + CW'(1);
				held0_d  = held1_q;
				held1_d  = sval;
				if (wcount_q >= CW'(sfd_pkg::CRC_BYTES)) begin
					crc_d = crc_feed(crc_base, held0_q, cfg.poly);
				end
			end
		end

		if (restart) begin
			wcount_d   = '0;
			in_frame_d = set_frame;
			esc_d      = 1'b0;
			crc_d      = cfg.init;
		end

		if (!accept) begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q   <= '0;
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			crc_q      <= sfd_pkg::CRC_INIT_RST;
			held0_q    <= '0;
			held1_q    <= '0;
		end else if (accept) begin
			wcount_q   <= wcount_d;
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			crc_q      <= crc_d;
			held0_q    <= held0_d;
			held1_q    <= held1_d;
		end
	end

endmodule

`default_nettype wire

/* test/slip_frame_decoder_crc_test.sv */
// Self-checking testbench for slip_frame_decoder_crc: SLIP deframing, CRC16 check, store reads.
// Drives the streaming and config ports, predicts every result beat and checks it in order.
// Depends on sfd_pkg and the slip_frame_decoder_crc RTL.
`timescale 1ns / 1ps

module slip_frame_decoder_crc_test;
	import sfd_pkg::*;

	localparam int STALL_LIMIT = 2000;	// cycles with no beat on any channel
	localparam int HOLD_CYCLES = 64;	// long receiver hold, fills the block

	// one expected result beat
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] flen;
		logic [7:0] rdata;
	} outcome_t;

	// Deframer state mirror plus the queue of results still owed by the block.
	class slip_tracker;
		logic [8:0]  cap_reg;
		logic [15:0] poly;
		logic [15:0] init_val;
		logic [15:0] fxor;
		logic [7:0]  store [256];
		bit          written [256];
		int          written_cnt;
		int          fill;
		bit          open;
		bit          esc;
		logic [15:0] crc_acc;
		logic [7:0]  tail0;
		logic [7:0]  tail1;
		outcome_t    outcomes_due [$];
		int          errors;

		function new();
			cap_reg     = MAX_LEN_RST;
			poly        = CRC_POLY_RST;
			init_val    = CRC_INIT_RST;
			fxor        = CRC_FXOR_RST;
			written_cnt = 0;
			errors      = 0;
			tail0       = '0;
			tail1       = '0;
			restart();
		endfunction

		// MSB-first CRC16, one byte
		function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b, logic [15:0] p);
			logic [15:0] r;
			r = c ^ {b, 8'h00};
			for (int k = 0; k < 8; k++)
				r = r[15] ? ((r << 1) ^ p) : (r << 1);
			return r;
		endfunction

		function int cap();
			return (cap_reg < 256) ? int'(cap_reg) : 256;
		endfunction

		function void restart();
			fill    = 0;
			open    = 1'b0;
			esc     = 1'b0;
			crc_acc = init_val;
		endfunction

		// store one unescaped byte; 0 when the store is full
		function bit push_byte(logic [7:0] b);
			if (fill >= cap())
				return 1'b0;
			store[fill] = b;
			if (!written[fill])
				written_cnt++;
			written[fill] = 1'b1;
			// CRC trails the store by two bytes; init is taken on the first fed byte
			if (fill >= CRC_BYTES)
				crc_acc = crc_byte((fill == CRC_BYTES) ? init_val : crc_acc, tail0, poly);
			tail0 = tail1;
			tail1 = b;
			fill++;
			return 1'b1;
		endfunction

		// random store position that already holds a byte
		function logic [7:0] pick_index();
			logic [7:0] i;
			if (written_cnt == 0)
				return 8'h00;
			i = 8'($urandom);
			while (!written[i])
				i = 8'($urandom);
			return i;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] d);
			case (idx)
				CFG_MAX_LEN:  cap_reg  = d[8:0];
				CFG_CRC_POLY: poly     = d;
				CFG_CRC_INIT: init_val = d;
				CFG_CRC_FXOR: fxor     = d;
				default: ;
			endcase
		endfunction

		// accepted input beat: update state, queue the result it owes
		function void note_beat(logic act, logic [7:0] b, logic [7:0] idx);
			outcome_t    o;
			logic [15:0] calc;
			logic [15:0] msg;
			int          n;
			o = '0;
			if (act) begin
				o.rdata = store[idx];
			end else if (esc) begin
				esc = 1'b0;
				if (b == SLIP_ESC_ESC || b == SLIP_ESC_END) begin
					if (!push_byte((b == SLIP_ESC_ESC) ? SLIP_ESC : SLIP_END)) begin
						restart();
						o.status = ST_LEN_ERR;
					end
				end else begin
					restart();
					o.status = ST_ESC_ERR;
				end
			end else if (b == SLIP_END) begin
				if (open && fill > MIN_FRAME_BYTES) begin
					calc = crc_acc ^ fxor;
					msg  = {tail0, tail1};
					n    = fill - CRC_BYTES;
					restart();
					if (calc == msg) begin
						o.status = ST_OK;
						o.flen   = (n > 255) ? 8'hFF : 8'(n);
					end else begin
						o.status = ST_CRC_ERR;
					end
				end else begin
					// short frame or no frame yet: (re)open
					restart();
					open = 1'b1;
				end
			end else if (b == SLIP_ESC) begin
				esc = 1'b1;
			end else if (!push_byte(b)) begin
				restart();
				o.status = ST_LEN_ERR;
			end
			outcomes_due.push_back(o);
		endfunction

		task report(string what, logic [7:0] got, logic [7:0] want);
			errors++;
			if (errors <= 100)
				$display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		endtask

		task check_beat(logic [2:0] st, logic [7:0] fl, logic [7:0] rd);
			outcome_t o;
			if (outcomes_due.size() == 0) begin
				report("result beat with nothing pending, status", 8'(st), 8'h00);
			end else begin
				o = outcomes_due.pop_front();
				if (st !== o.status)
					report("status", 8'(st), 8'(o.status));
				if (fl !== o.flen)
					report("frame_length", fl, o.flen);
				if (rd !== o.rdata)
					report("read_data", rd, o.rdata);
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;	// [7:0] rx_byte, [15:8] read_index
	logic        s_axis_tuser;	// [0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;	// [7:0] frame_length, [15:8] read_data
	logic [2:0]  m_axis_tuser;	// [2:0] status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	slip_tracker tracker;
	logic [7:0]  frame_body [$];	// unescaped payload of the next frame
	int          beats_sent;
	int          stall_cycles;
	bit          quiet;		// no idling on either side
	bit          hold_req;		// asks the receiver for one long hold

	slip_frame_decoder_crc i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: everything is sampled at the rising edge. Input beats are noted
	// before output beats are checked, register writes update the mirror.
	// The watchdog counts edges where no channel moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.note_beat(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_beat(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver: short random stalls, one long hold on request, none when quiet.
	// At most one assignment to tready per falling edge.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// All drive tasks start and end at a falling edge. tvalid stays high
	// between back-to-back beats and only drops for a gap or a drain.
	task automatic send_beat(logic act, logic [7:0] b, logic [7:0] idx);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {idx, b};
		do
			@(posedge clk);
		while (!s_axis_tready);
		beats_sent++;
		@(negedge clk);
	endtask

	// receive beat; read_index points at a written entry when one exists, even though it is unused
	task automatic send_rx(logic [7:0] b);
		send_beat(1'b0, b, tracker.pick_index());
	endtask

	// reads only ever hit entries that were written since reset
	task automatic send_read();
		if (tracker.written_cnt != 0)
			send_beat(1'b1, 8'($urandom_range(0, 255)), tracker.pick_index());
	endtask

	// one payload byte on the line, escaped if needed, sometimes followed by a read
	task automatic send_payload(logic [7:0] b);
		if (b == SLIP_END) begin
			send_rx(SLIP_ESC);
			send_rx(SLIP_ESC_END);
		end else if (b == SLIP_ESC) begin
			send_rx(SLIP_ESC);
			send_rx(SLIP_ESC_ESC);
		end else begin
			send_rx(b);
		end
		if ($urandom_range(0, 11) == 0)
			send_read();
	endtask

	// END, frame_body, big-endian CRC trailer, END; CRC from the current registers
	task automatic send_frame(bit bad_crc);
		logic [15:0] c;
		c = tracker.init_val;
		foreach (frame_body[k])
			c = tracker.crc_byte(c, frame_body[k], tracker.poly);
		c = c ^ tracker.fxor;
		if (bad_crc)
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		send_rx(SLIP_END);
		foreach (frame_body[k])
			send_payload(frame_body[k]);
		send_payload(c[15:8]);
		send_payload(c[7:0]);
		send_rx(SLIP_END);
	endtask

	// payload bytes lean toward the two codes that need escaping
	function automatic logic [7:0] rand_payload_byte();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? SLIP_END : SLIP_ESC;
		return 8'($urandom_range(0, 255));
	endfunction

	// stop offering, wait for every owed result, then idle before returning
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (tracker.outcomes_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// all four registers back to back, only while the block is idle
	task automatic set_config(logic [15:0] max_len, logic [15:0] p, logic [15:0] init,
			logic [15:0] fx);
		cfg_write(CFG_MAX_LEN, max_len);
		cfg_write(CFG_CRC_POLY, p);
		cfg_write(CFG_CRC_INIT, init);
		cfg_write(CFG_CRC_FXOR, fx);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly well-formed frames with random content; the rest is bad CRC,
	// overlong frames (small capacities only), escape errors, short frames,
	// line noise and read bursts.
	task automatic run_traffic(int budget);
		int stop;
		int r;
		int n;
		int c;
		int lim;
		int k;
		stop = beats_sent + budget;
		while (beats_sent < stop) begin
			c   = tracker.cap();
			lim = (c - 2 > 24) ? 24 : c - 2;
			if (lim < 3)
				lim = 3;
			r = $urandom_range(0, 99);
			if (r < 78) begin
				if (r >= 72 && c <= 40)
					n = $urandom_range((c - 4 < 3) ? 3 : c - 4, c + 1);
				else
					n = $urandom_range(3, lim);
				frame_body.delete();
				repeat (n) frame_body.push_back(rand_payload_byte());
				send_frame(r >= 62 && r < 72);
			end else if (r < 85) begin
				// escape followed by anything but the two legal codes
				send_rx(SLIP_END);
				repeat ($urandom_range(0, 3)) send_payload(rand_payload_byte());
				send_rx(SLIP_ESC);
				k = $urandom_range(0, 255);
				while (k == SLIP_ESC_END || k == SLIP_ESC_ESC)
					k = $urandom_range(0, 255);
				send_rx(8'(k));
			end else if (r < 91) begin
				// 4 or fewer bytes: END reopens instead of closing
				send_rx(SLIP_END);
				repeat ($urandom_range(0, 4)) send_payload(rand_payload_byte());
				send_rx(SLIP_END);
			end else if (r < 96) begin
				repeat ($urandom_range(1, 6)) send_rx(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) send_read();
			end
		end
	endtask

	initial begin
		tracker       = new();
		beats_sent    = 0;
		stall_cycles  = 0;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_MAX_LEN;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset register values
		send_rx(8'h00);			// bytes before any frame are stored ...
		send_rx(8'hFF);
		send_rx(SLIP_END);		// ... and dropped by the opening END
		send_rx(8'h01);
		send_rx(SLIP_END);		// short frame reopens
		frame_body = {8'h00, SLIP_ESC, SLIP_END, 8'hFF};
		send_frame(1'b0);		// both escapes, good CRC
		send_beat(1'b1, 8'h00, 8'd0);
		send_beat(1'b1, 8'hFF, 8'd3);
		send_rx(SLIP_ESC);
		send_rx(8'h41);			// escape error
		send_rx(SLIP_ESC);
		send_rx(SLIP_END);		// END right after ESC is an escape error too
		frame_body = {8'h5A, 8'hA5, 8'h3C};
		send_frame(1'b1);		// CRC error

		// full-size frame writes every store entry, then a long receiver hold
		drain();
		set_config(16'd256, 16'h1021, 16'hFFFF, 16'h0000);
		frame_body.delete();
		repeat (254) frame_body.push_back(rand_payload_byte());
		send_frame(1'b0);
		hold_req = 1'b1;
		run_traffic(70);

		// smallest capacity that closes a frame, zero poly and init, full xor
		drain();
		set_config(16'd5, 16'h0000, 16'h0000, 16'hFFFF);
		run_traffic(70);

		// capacity above the store (upper data bits set), all-ones poly;
		// sender pauses midway until nothing is owed
		drain();
		set_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		run_traffic(35);
		drain();
		run_traffic(35);

		// capacity below 5: no frame can close
		drain();
		set_config(16'd3, 16'($urandom), 16'($urandom), 16'($urandom));
		run_traffic(50);

		// random settings; the last one without idling
		for (int ph = 0; ph < 3; ph++) begin
			drain();
			set_config(16'($urandom_range(5, 40)), 16'($urandom), 16'($urandom),
				16'($urandom));
			if (ph == 2)
				quiet = 1'b1;
			run_traffic(70);
		end

		drain();
		repeat (10) @(negedge clk);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
